/* rtl/core/nnis_pkg.sv */
// Shared types and constants for the nearest-neighbor image scaler.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package nnis_pkg;

  // Default values for the top-level parameters
  localparam int DEF_MAX_SOURCE_WIDTH   = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT  = 256;
  localparam int DEF_STEP_FRACTION_BITS = 16;

  // Fixed field widths
  localparam int COORD_W     = 12;
  localparam int PIXEL_W     = 32;
  localparam int SRC_SIZE_W  = 9;
  localparam int TGT_SIZE_W  = 13;
  localparam int STEP_W      = 24;
  localparam int LIMIT_W     = 13;
  localparam int PROD_W      = COORD_W + STEP_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_STEP  = 3'd4;

  // Register reset values
  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_WIDTH  = 9'd256;
  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_HEIGHT = 9'd256;
  localparam logic [TGT_SIZE_W-1:0] RST_TARGET_WIDTH  = 13'd256;
  localparam logic [TGT_SIZE_W-1:0] RST_TARGET_HEIGHT = 13'd256;
  localparam logic [STEP_W-1:0]     RST_INVERSE_STEP  = 24'd65536;

  // Operation codes of an input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // What the back end does with a queued word
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_RANGE
  } kind_t;

  localparam int KIND_W = 2;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line_index;
    logic [PIXEL_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               out_of_range;
  } result_t;

  typedef struct packed {
    logic [SRC_SIZE_W-1:0] source_width;
    logic [SRC_SIZE_W-1:0] source_height;
    logic [TGT_SIZE_W-1:0] target_width;
    logic [TGT_SIZE_W-1:0] target_height;
    logic [STEP_W-1:0]     inverse_step;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/nearest_neighbor_image_scaler.sv */
// Nearest-neighbor frame-buffer scaler: sustained one word per clock unless results
// back up and the queue fills. A fetch result passes a multiply, the address map,
// the queue and the frame-store read; the single-port store access sets the rate.
// Loads give no result; loads outside the source size are dropped at the front.
// Synchronous reset clears control state and sets the registers to their defaults;
// the frame store is not cleared.
`default_nettype none

module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH   = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT  = DEF_MAX_SOURCE_HEIGHT,
  parameter int STEP_FRACTION_BITS = DEF_STEP_FRACTION_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire item_t                  item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result
);

  localparam int ADDR_W  = $clog2(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT);
  localparam int ENTRY_W = KIND_W + ADDR_W + PIXEL_W;

  cfg_t               cfg_regs;
  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.source_width  <= RST_SOURCE_WIDTH;
      cfg_regs.source_height <= RST_SOURCE_HEIGHT;
      cfg_regs.target_width  <= RST_TARGET_WIDTH;
      cfg_regs.target_height <= RST_TARGET_HEIGHT;
      cfg_regs.inverse_step  <= RST_INVERSE_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  cfg_regs.source_width  <= cfg_data[SRC_SIZE_W-1:0];
        REG_SOURCE_HEIGHT: cfg_regs.source_height <= cfg_data[SRC_SIZE_W-1:0];
        REG_TARGET_WIDTH:  cfg_regs.target_width  <= cfg_data[TGT_SIZE_W-1:0];
        REG_TARGET_HEIGHT: cfg_regs.target_height <= cfg_data[TGT_SIZE_W-1:0];
        REG_INVERSE_STEP:  cfg_regs.inverse_step  <= cfg_data[STEP_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  nnis_front #(
    .MAX_SOURCE_WIDTH   (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT  (MAX_SOURCE_HEIGHT),
    .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full)
  );

  nnis_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  nnis_back #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .valid        (q_valid),
    .pop_data     (q_pop_data),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

/* rtl/core/nnis_front.sv */
// Front end: accepts words, drops loads outside the source, classifies
// fetches and maps them to a frame-store address. Uses nnis_pkg.
`default_nettype none

module nnis_front
  import nnis_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH   = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT  = DEF_MAX_SOURCE_HEIGHT,
  parameter int STEP_FRACTION_BITS = DEF_STEP_FRACTION_BITS,
  localparam int COL_W   = $clog2(MAX_SOURCE_WIDTH),
  localparam int ROW_W   = $clog2(MAX_SOURCE_HEIGHT),
  localparam int ADDR_W  = $clog2(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT),
  localparam int ENTRY_W = KIND_W + ADDR_W + PIXEL_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire item_t              item,
  output logic                    push,
  output logic [ENTRY_W-1:0]      push_data,
  input  wire logic               full
);

  localparam int SRC_W = PROD_W - STEP_FRACTION_BITS;

  logic [LIMIT_W-1:0] sw_ext;
  logic [LIMIT_W-1:0] sh_ext;
  logic [LIMIT_W-1:0] eff_w;
  logic [LIMIT_W-1:0] eff_h;
  logic [LIMIT_W-1:0] col_ext;
  logic [LIMIT_W-1:0] row_ext;
  logic               load_ok;
  logic               fetch_oor;
  logic               keep;
  kind_t              kind_in;
  logic [PROD_W-1:0]  prod_c;
  logic [PROD_W-1:0]  prod_r;

  logic               s1_valid;
  kind_t              s1_kind;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic [PROD_W-1:0]  s1_prod_c;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [PIXEL_W-1:0] s1_pixel;

  logic [SRC_W-1:0]   src_c;
  logic [SRC_W-1:0]   src_r;
  logic [SRC_W-1:0]   lim_c;
  logic [SRC_W-1:0]   lim_r;
  logic [SRC_W-1:0]   clamp_c;
  logic [SRC_W-1:0]   clamp_r;
  logic [COL_W-1:0]   col_sel;
  logic [ROW_W-1:0]   row_sel;
  logic [ADDR_W-1:0]  addr_next;

  logic               s2_valid;
  logic               s2_free;
  kind_t              s2_kind;
  logic [ADDR_W-1:0]  s2_addr;
  logic [PIXEL_W-1:0] s2_pixel;

  // Effective source size: zero acts as one, capped at the store size
  always_comb begin
    sw_ext = LIMIT_W'(cfg.source_width);
    sh_ext = LIMIT_W'(cfg.source_height);
    if (sw_ext == '0) begin
      eff_w = LIMIT_W'(1);
    end else if (sw_ext > LIMIT_W'(MAX_SOURCE_WIDTH)) begin
      eff_w = LIMIT_W'(MAX_SOURCE_WIDTH);
    end else begin
      eff_w = sw_ext;
    end
    if (sh_ext == '0) begin
      eff_h = LIMIT_W'(1);
    end else if (sh_ext > LIMIT_W'(MAX_SOURCE_HEIGHT)) begin
      eff_h = LIMIT_W'(MAX_SOURCE_HEIGHT);
    end else begin
      eff_h = sh_ext;
    end
  end

  // Classify the incoming word
  always_comb begin
    col_ext   = LIMIT_W'(item.column);
    row_ext   = LIMIT_W'(item.line_index);
    load_ok   = (col_ext < eff_w) && (row_ext < eff_h);
    fetch_oor = (col_ext >= cfg.target_width) || (row_ext >= cfg.target_height);
    if (item.op == OP_LOAD) begin
      kind_in = KIND_WRITE;
      keep    = load_ok;
    end else begin
      kind_in = fetch_oor ? KIND_RANGE : KIND_READ;
      keep    = 1'b1;
    end
    prod_c = PROD_W'(item.column) * PROD_W'(cfg.inverse_step);
    prod_r = PROD_W'(item.line_index) * PROD_W'(cfg.inverse_step);
  end

  assign s2_free    = !s2_valid || !full;
  assign item_ready = !s1_valid || s2_free;
  assign push       = s2_valid && !full;
  assign push_data  = {s2_kind, s2_addr, s2_pixel};

  // For fetches drop the fraction, clamp to the last source column and row
  always_comb begin
    src_c   = s1_prod_c[PROD_W-1:STEP_FRACTION_BITS];
    src_r   = s1_prod_r[PROD_W-1:STEP_FRACTION_BITS];
    lim_c   = SRC_W'(eff_w - LIMIT_W'(1));
    lim_r   = SRC_W'(eff_h - LIMIT_W'(1));
    clamp_c = (src_c > lim_c) ? lim_c : src_c;
    clamp_r = (src_r > lim_r) ? lim_r : src_r;
    if (s1_kind == KIND_WRITE) begin
      col_sel = s1_col[COL_W-1:0];
      row_sel = s1_row[ROW_W-1:0];
    end else begin
      col_sel = clamp_c[COL_W-1:0];
      row_sel = clamp_r[ROW_W-1:0];
    end
    addr_next = ADDR_W'(row_sel) * ADDR_W'(MAX_SOURCE_WIDTH) + ADDR_W'(col_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid && keep;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_kind   <= kind_in;
      s1_col    <= item.column;
      s1_row    <= item.line_index;
      s1_prod_c <= prod_c;
      s1_prod_r <= prod_r;
      s1_pixel  <= item.pixel_in;
    end
    if (s2_free && s1_valid) begin
      s2_kind  <= s1_kind;
      s2_addr  <= addr_next;
      s2_pixel <= s1_pixel;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nnis_queue.sv */
// Short register FIFO between the scaler front and back ends.
// Uses nnis_pkg for the queue depth.
`default_nettype none

module nnis_queue
  import nnis_pkg::*;
#(
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nnis_back.sv */
// Back end: frame-store memory, carries out queued writes and reads,
// holds the result word. Uses nnis_pkg.
`default_nettype none

module nnis_back
  import nnis_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  localparam int DEPTH   = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT,
  localparam int ADDR_W  = $clog2(DEPTH),
  localparam int ENTRY_W = KIND_W + ADDR_W + PIXEL_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  input  wire logic [ENTRY_W-1:0] pop_data,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output result_t                 result
);

  logic [PIXEL_W-1:0] frame_store [DEPTH];
  logic [PIXEL_W-1:0] mem_q;

  kind_t              e_kind;
  logic [ADDR_W-1:0]  e_addr;
  logic [PIXEL_W-1:0] e_pixel;
  logic               is_write;
  logic               wr_en;
  logic               rd_en;

  logic               b_valid;
  kind_t              b_kind;

  assign e_kind  = kind_t'(pop_data[ENTRY_W-1 -: KIND_W]);
  assign e_addr  = pop_data[PIXEL_W +: ADDR_W];
  assign e_pixel = pop_data[PIXEL_W-1:0];

  // Writes need no result slot; reads and range answers wait for one
  assign is_write = (e_kind == KIND_WRITE);
  assign pop      = valid && (is_write || !b_valid || result_ready);
  assign wr_en    = pop && is_write;
  assign rd_en    = pop && (e_kind == KIND_READ);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[e_addr] <= e_pixel;
    end
    // Hold read data while the result waits
    if (rd_en) begin
      mem_q <= frame_store[e_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop && !is_write) begin
      b_valid <= 1'b1;
    end else if (result_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_write) begin
      b_kind <= e_kind;
    end
  end

  assign result_valid        = b_valid;
  assign result.pixel_out    = (b_kind == KIND_READ) ? mem_q : '0;
  assign result.out_of_range = (b_kind == KIND_RANGE);

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for nearest_neighbor_image_scaler.
// Mirrors the frame store and scale registers to predict every fetch result;
// depends only on nnis_pkg and the scaler RTL.
`timescale 1ns / 1ps

module tb
  import nnis_pkg::*;
();

  localparam int MAX_W         = DEF_MAX_SOURCE_WIDTH;
  localparam int MAX_H         = DEF_MAX_SOURCE_HEIGHT;
  localparam int FRAC_BITS     = DEF_STEP_FRACTION_BITS;
  localparam int STORE_DEPTH   = MAX_W * MAX_H;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 200000;
  // Index outside the register map; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_valid    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   item_valid   = 1'b0;
  item_t                  item         = '0;
  logic                   result_ready = 1'b0;
  logic                   cfg_ready;
  logic                   item_ready;
  logic                   result_valid;
  result_t                result;

  // Register mirror, starting at the reset defaults
  logic [SRC_SIZE_W-1:0] cur_src_w = RST_SOURCE_WIDTH;
  logic [SRC_SIZE_W-1:0] cur_src_h = RST_SOURCE_HEIGHT;
  logic [TGT_SIZE_W-1:0] cur_tgt_w = RST_TARGET_WIDTH;
  logic [TGT_SIZE_W-1:0] cur_tgt_h = RST_TARGET_HEIGHT;
  logic [STEP_W-1:0]     cur_step  = RST_INVERSE_STEP;

  logic [PIXEL_W-1:0] frame_mirror [0:STORE_DEPTH-1];
  bit                 frame_loaded [0:STORE_DEPTH-1];
  result_t            expected_pixels [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ticket    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int results_seen   = 0;
  int loads_kept     = 0;
  int loads_dropped  = 0;
  int fetches        = 0;
  int fetches_outside = 0;
  int reg_writes     = 0;
  int settings_count = 0;

  nearest_neighbor_image_scaler DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Zero acts as one, anything above the store size acts as the maximum.
  function automatic int unsigned eff_size(input int unsigned reg_val,
                                           input int unsigned max_val);
    if (reg_val == 0) return 1;
    if (reg_val > max_val) return max_val;
    return reg_val;
  endfunction

  function automatic int unsigned source_coord(input logic [COORD_W-1:0] c,
                                               input int unsigned limit);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] src;
    prod = {{STEP_W{1'b0}}, c} * {{COORD_W{1'b0}}, cur_step};
    src = prod >> FRAC_BITS;
    if (src > limit - 1) return limit - 1;
    return int'(src);
  endfunction

  // Apply one accepted word to the mirror; returns 1 when it yields a result.
  function automatic bit scale_lookup(input item_t w, output result_t r);
    int unsigned sw;
    int unsigned sh;
    int unsigned addr;
    sw = eff_size(32'(cur_src_w), MAX_W);
    sh = eff_size(32'(cur_src_h), MAX_H);
    r = '0;
    if (w.op == OP_LOAD) begin
      if (w.column < sw && w.line_index < sh) begin
        addr = w.line_index * MAX_W + w.column;
        frame_mirror[addr] = w.pixel_in;
        frame_loaded[addr] = 1'b1;
        loads_kept++;
      end else begin
        loads_dropped++;
      end
      return 1'b0;
    end
    fetches++;
    if (w.column >= cur_tgt_w || w.line_index >= cur_tgt_h) begin
      r.out_of_range = 1'b1;
      fetches_outside++;
      return 1'b1;
    end
    addr = source_coord(w.line_index, sh) * MAX_W + source_coord(w.column, sw);
    r.pixel_out = frame_mirror[addr];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                 input logic [PIXEL_W-1:0] want);
    $display("mismatch at result %0d: %0s got %h want %h (cycle %0d)",
             results_seen, what, got, want, cycle_count);
    error_count++;
  endtask

  // Receiver: random stalls plus the long hold, and the result check.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected word", result.pixel_out, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (result.pixel_out !== want.pixel_out)
            report_mismatch("pixel_out", result.pixel_out, want.pixel_out);
          if (result.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", PIXEL_W'(result.out_of_range),
                            PIXEL_W'(want.out_of_range));
        end
        results_seen++;
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold, started by bumping hold_ticket.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic send_item(input logic op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [PIXEL_W-1:0] pix);
    item_t   w;
    result_t r;
    int      gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    w.op = op;
    w.column = col;
    w.line_index = row;
    w.pixel_in = pix;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (scale_lookup(w, r)) expected_pixels.push_back(r);
  endtask

  // Fetch one output pixel; for an on-target pixel, load its source entry first if never written.
  task automatic fetch_at(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int unsigned sc;
    int unsigned sr;
    if (col < cur_tgt_w && row < cur_tgt_h) begin
      sc = source_coord(col, eff_size(32'(cur_src_w), MAX_W));
      sr = source_coord(row, eff_size(32'(cur_src_h), MAX_H));
      if (!frame_loaded[sr * MAX_W + sc])
        send_item(OP_LOAD, sc[COORD_W-1:0], sr[COORD_W-1:0], $urandom());
    end
    send_item(OP_FETCH, col, row, $urandom());
  endtask

  // Drop valid, drain all results, then let trailing loads retire.
  task automatic settle_block();
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  cur_src_w = data[SRC_SIZE_W-1:0];
      REG_SOURCE_HEIGHT: cur_src_h = data[SRC_SIZE_W-1:0];
      REG_TARGET_WIDTH:  cur_tgt_w = data[TGT_SIZE_W-1:0];
      REG_TARGET_HEIGHT: cur_tgt_h = data[TGT_SIZE_W-1:0];
      REG_INVERSE_STEP:  cur_step = data[STEP_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                                input logic [CFG_DATA_W-1:0] tw, input logic [CFG_DATA_W-1:0] th,
                                input logic [CFG_DATA_W-1:0] step);
    write_register(REG_SOURCE_WIDTH, sw);
    write_register(REG_SOURCE_HEIGHT, sh);
    write_register(REG_TARGET_WIDTH, tw);
    write_register(REG_TARGET_HEIGHT, th);
    write_register(REG_INVERSE_STEP, step);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic test_register_defaults();
    send_item(OP_LOAD, 12'd0, 12'd0, 32'hFFFFFFFF);
    send_item(OP_LOAD, 12'd0, 12'd0, 32'h00000000);
    // read right behind the overwrite
    send_item(OP_FETCH, 12'd0, 12'd0, 32'hFFFFFFFF);
    send_item(OP_LOAD, 12'd255, 12'd255, 32'hA5A5A5A5);
    send_item(OP_LOAD, 12'd255, 12'd0, 32'h5A5A5A5A);
    send_item(OP_LOAD, 12'd0, 12'd1, 32'h12345678);
    // column 256 would alias row 1 if not dropped
    send_item(OP_LOAD, 12'd256, 12'd0, 32'hDEADBEEF);
    send_item(OP_LOAD, 12'd4095, 12'd4095, 32'hFFFFFFFF);
    fetch_at(12'd255, 12'd255);
    fetch_at(12'd255, 12'd0);
    fetch_at(12'd0, 12'd1);
    fetch_at(12'd256, 12'd0);
    fetch_at(12'd0, 12'd256);
    fetch_at(12'd4095, 12'd4095);
  endtask

  task automatic test_edge_settings();
    settle_block();
    write_register(REG_SPARE, 24'hFFFFFF);
    // upper data bits are discarded: source 5 x 3, zero step maps to the corner
    apply_settings(24'hFFFE05, 24'd3, 24'd8191, 24'd8191, 24'd0);
    send_item(OP_LOAD, 12'd5, 12'd0, 32'hFFFFFFFF);
    send_item(OP_LOAD, 12'd0, 12'd3, 32'hFFFFFFFF);
    fetch_at(12'd4095, 12'd4095);
    fetch_at(12'd0, 12'd0);
    settle_block();
    // zero source acts as one; zero target width rejects every fetch
    apply_settings(24'd0, 24'd0, 24'd0, 24'd5, 24'hFFFFFF);
    send_item(OP_LOAD, 12'd1, 12'd0, 32'hFFFFFFFF);
    send_item(OP_LOAD, 12'd0, 12'd0, 32'h0F0F0F0F);
    fetch_at(12'd0, 12'd0);
    settle_block();
    apply_settings(24'd0, 24'd0, 24'd4096, 24'd0, 24'hFFFFFF);
    fetch_at(12'd4095, 12'd0);
    settle_block();
    apply_settings(24'd0, 24'd0, 24'd4096, 24'd4096, 24'hFFFFFF);
    fetch_at(12'd4095, 12'd1);
    settle_block();
    // oversized source acts as the full store; max step clamps to the edge
    apply_settings(24'd511, 24'd300, 24'd256, 24'd256, 24'hFFFFFF);
    send_item(OP_LOAD, 12'd256, 12'd0, 32'hFFFFFFFF);
    fetch_at(12'd1, 12'd1);
    fetch_at(12'd255, 12'd0);
    settle_block();
    apply_settings(24'd4, 24'd4, 24'd16, 24'd16, 24'h004000);
    fetch_at(12'd15, 12'd15);
    fetch_at(12'd16, 12'd0);
    fetch_at(12'd0, 12'd16);
    fetch_at(12'd7, 12'd9);
  endtask

  task automatic test_random_traffic(input int rounds, input int count);
    int unsigned sw;
    int unsigned sh;
    int unsigned tw;
    int unsigned th;
    int unsigned step;
    int unsigned pick;
    for (int k = 0; k < rounds; k++) begin
      settle_block();
      pick = $urandom_range(9);
      sw = (pick < 6) ? $urandom_range(1, 16) : (pick < 9) ? $urandom_range(1, 256)
                                                           : $urandom_range(0, 511);
      pick = $urandom_range(9);
      sh = (pick < 6) ? $urandom_range(1, 16) : (pick < 9) ? $urandom_range(1, 256)
                                                           : $urandom_range(0, 511);
      case ($urandom_range(2))
        0: step = $urandom_range(4096, 65536);
        1: step = $urandom_range(65536, 524288);
        default: step = $urandom_range(0, 24'hFFFFFF);
      endcase
      // target near the true scaled size, a little over to hit the clamp
      tw = (step == 0) ? 4096 : (eff_size(sw, MAX_W) << FRAC_BITS) / step;
      th = (step == 0) ? 4096 : (eff_size(sh, MAX_H) << FRAC_BITS) / step;
      if (tw > 4096) tw = 4096;
      if (th > 4096) th = 4096;
      tw = tw + $urandom_range(0, 2);
      th = th + $urandom_range(0, 2);
      if ($urandom_range(7) == 0) tw = $urandom_range(0, 8191);
      if ($urandom_range(7) == 0) th = $urandom_range(0, 8191);
      apply_settings(CFG_DATA_W'(sw), CFG_DATA_W'(sh), CFG_DATA_W'(tw), CFG_DATA_W'(th),
                     CFG_DATA_W'(step));
      sw = eff_size(32'(cur_src_w), MAX_W);
      sh = eff_size(32'(cur_src_h), MAX_H);
      tw = (cur_tgt_w > 4096) ? 4096 : cur_tgt_w;
      th = (cur_tgt_h > 4096) ? 4096 : cur_tgt_h;
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(99);
        if (pick < 45 && tw > 0 && th > 0)
          fetch_at(COORD_W'($urandom_range(0, tw - 1)), COORD_W'($urandom_range(0, th - 1)));
        else if (pick < 58)
          fetch_at(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
        else if (pick < 88)
          send_item(OP_LOAD, COORD_W'($urandom_range(0, sw - 1)),
                    COORD_W'($urandom_range(0, sh - 1)), $urandom());
        else
          send_item(OP_LOAD, COORD_W'($urandom_range(0, 4095)),
                    COORD_W'($urandom_range(0, 4095)), $urandom());
      end
    end
  endtask

  // Hold the receiver while fetches keep coming, so the input stalls.
  task automatic test_backpressure();
    settle_block();
    apply_settings(24'd8, 24'd8, 24'd8, 24'd8, 24'h010000);
    hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < 48; i++)
      fetch_at(COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 16;
    recv_stall_pct = 81;
    test_register_defaults();
    test_edge_settings();
    test_random_traffic(2, 120);
    settle_block();
    send_idle_pct = 81;
    recv_stall_pct = 16;
    test_random_traffic(2, 120);
    settle_block();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(2, 120);
    test_backpressure();
    settle_block();
    $display("ran %0d loads (%0d dropped outside the source) and %0d fetches (%0d off target)",
             loads_kept + loads_dropped, loads_dropped, fetches, fetches_outside);
    $display("%0d register writes over %0d settings, %0d results checked, %0d mismatches",
             reg_writes, settings_count, results_seen, error_count);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
